>>> hdl/rfch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfch_pkg: shared types and arithmetic helpers for the cylinder hit unit
// Wide saturating fixed-point values, split multiplier partial products and
// the register map of the configuration port.
// ----------------------------------------------------------------------------
package rfch_pkg;

  // Wide intermediate: signed, saturated symmetrically to +-(2^62-1).
  typedef logic signed [62:0] wide_t;
  typedef logic [61:0]        mag_t;

  localparam mag_t  MAG_MAX  = '1;
  localparam wide_t WIDE_MAX = {1'b0, MAG_MAX};
  localparam logic signed [63:0] S_MAX = {2'b00, MAG_MAX};

  // Result buffer behind the pipeline; it must exceed the pipeline latency.
  localparam int FIFO_DEPTH = 512;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  typedef logic [FIFO_AW:0] cnt_t;

  typedef enum logic [2:0] {
    REG_BASE_X = 3'd0,
    REG_BASE_Y = 3'd1,
    REG_BASE_Z = 3'd2,
    REG_AXIS_X = 3'd3,
    REG_AXIS_Y = 3'd4,
    REG_AXIS_Z = 3'd5,
    REG_RADIUS = 3'd6,
    REG_SPAN   = 3'd7
  } reg_idx_t;

  // Four 31x31 partial products of a 62x62 magnitude product.
  typedef struct packed {
    logic [61:0] p11;
    logic [61:0] p10;
    logic [61:0] p01;
    logic [61:0] p00;
  } part_t;

  typedef struct packed {
    logic  kill;
    wide_t a;
    wide_t h;
    wide_t dv;
    wide_t xv;
  } sq_carry_t;

  typedef struct packed {
    logic  kill;
    logic  neg1;
    logic  neg2;
    mag_t  den;
    wide_t dv;
    wide_t xv;
  } dv_carry_t;

  function automatic mag_t mag_of(wide_t v);
    wide_t n;
    n = -v;
    return v[62] ? n[61:0] : v[61:0];
  endfunction

  function automatic wide_t from_mag(mag_t m, logic neg);
    wide_t w;
    w = {1'b0, m};
    return neg ? -w : w;
  endfunction

  function automatic wide_t sadd(wide_t a, wide_t b);
    logic signed [63:0] s;
    s = {a[62], a} + {b[62], b};
    if (s > S_MAX) begin
      return WIDE_MAX;
    end
    if (s < -S_MAX) begin
      return -WIDE_MAX;
    end
    return s[62:0];
  endfunction

  function automatic part_t mul_parts(mag_t a, mag_t b);
    part_t p;
    p.p00 = a[30:0] * b[30:0];
    p.p01 = a[30:0] * b[61:31];
    p.p10 = a[61:31] * b[30:0];
    p.p11 = a[61:31] * b[61:31];
    return p;
  endfunction

  function automatic logic [123:0] parts_sum(part_t p);
    return {62'b0, p.p00} + {31'b0, p.p01, 31'b0} + {31'b0, p.p10, 31'b0}
           + {p.p11, 62'b0};
  endfunction

  // Drop the fraction bits (toward zero on the magnitude) and saturate.
  function automatic wide_t scale_sat(logic [123:0] prod, logic neg, int unsigned shift);
    logic [123:0] m;
    mag_t         mm;
    m  = prod >> shift;
    mm = (m > {62'b0, MAG_MAX}) ? MAG_MAX : m[61:0];
    return from_mag(mm, neg);
  endfunction

  function automatic wide_t mulq33(logic signed [32:0] p, logic signed [32:0] q,
                                   int unsigned shift);
    logic [32:0] mp;
    logic [32:0] mq;
    logic [65:0] pr;
    mp = p[32] ? 33'(-p) : p;
    mq = q[32] ? 33'(-q) : q;
    pr = mp * mq;
    return scale_sat({58'b0, pr}, p[32] ^ q[32], shift);
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

>>> hdl/ray_finite_cylinder_hit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_finite_cylinder_hit_unit: ray against finite cylinder test
// Accepts one ray per clock while s_axis_tready is high and returns the
// nearest hit distance on a finite cylinder held in registers, with the
// matching axis point.
// The unit takes a new ray in every clock cycle while s_axis_tready is high
// and returns one result per ray, in order; values are Q16.16 at the default
// FRAC_BITS. Most of the pipeline is the 64-stage square root of the
// discriminant and the two quotient pipelines of 62 + FRAC_BITS stages
// each. Results collect in a 512-entry buffer, and a ray is taken only
// while the buffer has room for every ray in flight, so a stalled output
// holds off input only once that room is used up. Write the registers
// only while no ray is in flight.
module ray_finite_cylinder_hit_unit
  import rfch_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_distance[30:0], axis_point_x, axis_point_y, axis_point_z, one pad bit
  output logic [127:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int DIV_N = 62 + FRAC_BITS;

  // Configuration registers
  logic [31:0] base_x, base_y, base_z, axis_x, axis_y, axis_z;
  logic [30:0] radius, span_length;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x      <= '0;
      base_y      <= '0;
      base_z      <= '0;
      axis_x      <= '0;
      axis_y      <= 32'(64'd1 << FRAC_BITS);
      axis_z      <= '0;
      radius      <= 31'(64'd1 << FRAC_BITS);
      span_length <= 31'(64'd1 << FRAC_BITS);
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_BASE_X: base_x      <= pwdata;
        REG_BASE_Y: base_y      <= pwdata;
        REG_BASE_Z: base_z      <= pwdata;
        REG_AXIS_X: axis_x      <= pwdata;
        REG_AXIS_Y: axis_y      <= pwdata;
        REG_AXIS_Z: axis_z      <= pwdata;
        REG_RADIUS: radius      <= pwdata[30:0];
        REG_SPAN:   span_length <= pwdata[30:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_BASE_X: prdata = base_x;
      REG_BASE_Y: prdata = base_y;
      REG_BASE_Z: prdata = base_z;
      REG_AXIS_X: prdata = axis_x;
      REG_AXIS_Y: prdata = axis_y;
      REG_AXIS_Z: prdata = axis_z;
      REG_RADIUS: prdata = {1'b0, radius};
      REG_SPAN:   prdata = {1'b0, span_length};
      default:    prdata = '0;
    endcase
  end

  logic signed [31:0] base_v [3];
  logic signed [31:0] axis_v [3];
  assign base_v[0] = base_x;
  assign base_v[1] = base_y;
  assign base_v[2] = base_z;
  assign axis_v[0] = axis_x;
  assign axis_v[1] = axis_y;
  assign axis_v[2] = axis_z;

  // Admission: occ counts rays taken whose results are not yet delivered.
  cnt_t occ, fcnt;
  logic acc_in, out_acc;
  assign s_axis_tready = (occ < cnt_t'(FIFO_DEPTH));
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + cnt_t'(acc_in) - cnt_t'(out_acc);
    end
  end

  // Stage 0: relative origin X = O - B
  logic               v0;
  logic signed [32:0] rel0 [3];
  logic signed [31:0] dir0 [3];

  always_ff @(posedge clk) begin
    v0 <= rst ? 1'b0 : acc_in;
    for (int k = 0; k < 3; k++) begin
      rel0[k] <= {s_axis_tdata[32*k+31], s_axis_tdata[32*k +: 32]}
                 - {base_v[k][31], base_v[k]};
      dir0[k] <= s_axis_tdata[96+32*k +: 32];
    end
  end

  // Stage 1: the fifteen component products
  logic  v1;
  wide_t pdd [3], pdv [3], pxv [3], pdx [3], pxx [3];

  always_ff @(posedge clk) begin
    v1 <= rst ? 1'b0 : v0;
    for (int k = 0; k < 3; k++) begin
      pdd[k] <= mulq33({dir0[k][31], dir0[k]}, {dir0[k][31], dir0[k]}, FRAC_BITS);
      pdv[k] <= mulq33({dir0[k][31], dir0[k]}, {axis_v[k][31], axis_v[k]}, FRAC_BITS);
      pxv[k] <= mulq33(rel0[k], {axis_v[k][31], axis_v[k]}, FRAC_BITS);
      pdx[k] <= mulq33({dir0[k][31], dir0[k]}, rel0[k], FRAC_BITS);
      pxx[k] <= mulq33(rel0[k], rel0[k], FRAC_BITS);
    end
  end

  // Stage 2: dot products
  logic  v2;
  wide_t dd2, dv2, xv2, dx2, xx2;

  always_ff @(posedge clk) begin
    v2  <= rst ? 1'b0 : v1;
    dd2 <= sadd(sadd(pdd[0], pdd[1]), pdd[2]);
    dv2 <= sadd(sadd(pdv[0], pdv[1]), pdv[2]);
    xv2 <= sadd(sadd(pxv[0], pxv[1]), pxv[2]);
    dx2 <= sadd(sadd(pdx[0], pdx[1]), pdx[2]);
    xx2 <= sadd(sadd(pxx[0], pxx[1]), pxx[2]);
  end

  // Stage 3: partial products of the axial terms and of radius*radius
  logic  v3, neg_dvxv3;
  part_t pp_dvdv3, pp_dvxv3, pp_xvxv3, pp_rr3;
  wide_t dd3, dv3, xv3, dx3, xx3;

  always_ff @(posedge clk) begin
    v3        <= rst ? 1'b0 : v2;
    pp_dvdv3  <= mul_parts(mag_of(dv2), mag_of(dv2));
    pp_dvxv3  <= mul_parts(mag_of(dv2), mag_of(xv2));
    pp_xvxv3  <= mul_parts(mag_of(xv2), mag_of(xv2));
    pp_rr3    <= mul_parts(mag_t'(radius), mag_t'(radius));
    neg_dvxv3 <= dv2[62] ^ xv2[62];
    dd3       <= dd2;
    dv3       <= dv2;
    xv3       <= xv2;
    dx3       <= dx2;
    xx3       <= xx2;
  end

  // Stage 4: finish the axial products and radius*radius
  logic  v4;
  wide_t q_dvdv4, q_dvxv4, q_xvxv4, q_rr4, dd4, dv4, xv4, dx4, xx4;

  always_ff @(posedge clk) begin
    v4      <= rst ? 1'b0 : v3;
    q_dvdv4 <= scale_sat(parts_sum(pp_dvdv3), 1'b0, FRAC_BITS);
    q_dvxv4 <= scale_sat(parts_sum(pp_dvxv3), neg_dvxv3, FRAC_BITS);
    q_xvxv4 <= scale_sat(parts_sum(pp_xvxv3), 1'b0, FRAC_BITS);
    q_rr4   <= scale_sat(parts_sum(pp_rr3), 1'b0, FRAC_BITS);
    dd4     <= dd3;
    dv4     <= dv3;
    xv4     <= xv3;
    dx4     <= dx3;
    xx4     <= xx3;
  end

  // Stage 5: quadratic coefficients a, h and the first part of c
  logic  v5;
  wide_t a5, h5, c5, q_rr5, dv5, xv5;

  always_ff @(posedge clk) begin
    v5    <= rst ? 1'b0 : v4;
    a5    <= sadd(dd4, -q_dvdv4);
    h5    <= sadd(dx4, -q_dvxv4);
    c5    <= sadd(xx4, -q_xvxv4);
    q_rr5 <= q_rr4;
    dv5   <= dv4;
    xv5   <= xv4;
  end

  // Stage 6: c
  logic  v6;
  wide_t a6, h6, c6, dv6, xv6;

  always_ff @(posedge clk) begin
    v6  <= rst ? 1'b0 : v5;
    c6  <= sadd(c5, -q_rr5);
    a6  <= a5;
    h6  <= h5;
    dv6 <= dv5;
    xv6 <= xv5;
  end

  // Stage 7: partial products of h*h and a*c
  logic  v7, acneg7, azero7;
  part_t pp_hh7, pp_ac7;
  wide_t a7, h7, dv7, xv7;

  always_ff @(posedge clk) begin
    v7     <= rst ? 1'b0 : v6;
    pp_hh7 <= mul_parts(mag_of(h6), mag_of(h6));
    pp_ac7 <= mul_parts(mag_of(a6), mag_of(c6));
    acneg7 <= a6[62] ^ c6[62];
    azero7 <= (a6 == '0);
    a7     <= a6;
    h7     <= h6;
    dv7    <= dv6;
    xv7    <= xv6;
  end

  // Stage 8: exact h*h and |a*c|
  logic         v8, acneg8, azero8;
  logic [123:0] hh8, ac8;
  wide_t        a8, h8, dv8, xv8;

  always_ff @(posedge clk) begin
    v8     <= rst ? 1'b0 : v7;
    hh8    <= parts_sum(pp_hh7);
    ac8    <= parts_sum(pp_ac7);
    acneg8 <= acneg7;
    azero8 <= azero7;
    a8     <= a7;
    h8     <= h7;
    dv8    <= dv7;
    xv8    <= xv7;
  end

  // Square root pipeline: index 0 holds the discriminant, one result bit
  // is settled per stage from the top.
  logic         sq_v    [65];
  logic [65:0]  sq_rem  [65];
  logic [63:0]  sq_root [65];
  logic [127:0] sq_disc [65];
  sq_carry_t    sq_c    [65];

  always_ff @(posedge clk) begin
    sq_v[0]    <= rst ? 1'b0 : v8;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_disc[0] <= acneg8 ? {4'b0, hh8} + {4'b0, ac8} : {4'b0, hh8} - {4'b0, ac8};
    sq_c[0]    <= '{kill: azero8 || (!acneg8 && (hh8 < ac8)),
                    a: a8, h: h8, dv: dv8, xv: xv8};
  end

  for (genvar g = 0; g < 64; g++) begin : g_sqrt
    logic [67:0] rsh;
    logic [65:0] trial;
    logic        take;

    always_comb begin
      rsh   = {sq_rem[g], sq_disc[g][2*(63-g)+1 -: 2]};
      trial = {sq_root[g], 2'b01};
      take  = (rsh >= {2'b00, trial});
    end

    always_ff @(posedge clk) begin
      sq_v[g+1]    <= rst ? 1'b0 : sq_v[g];
      sq_rem[g+1]  <= take ? 66'(rsh - {2'b00, trial}) : rsh[65:0];
      sq_root[g+1] <= {sq_root[g][62:0], take};
      sq_disc[g+1] <= sq_disc[g];
      sq_c[g+1]    <= sq_c[g];
    end
  end

  // Root numerators -h - s and -h + s
  wide_t s_root, n1, n2;

  always_comb begin
    s_root = (sq_root[64] > {2'b00, MAG_MAX}) ? WIDE_MAX : wide_t'({1'b0, sq_root[64][61:0]});
    n1     = sadd(-sq_c[64].h, -s_root);
    n2     = sadd(-sq_c[64].h, s_root);
  end

  // Quotient pipelines: num * 2^FRAC_BITS / den, one quotient bit per stage.
  logic             dq_v  [DIV_N+1];
  logic [61:0]      dq_r1 [DIV_N+1];
  logic [61:0]      dq_r2 [DIV_N+1];
  logic [DIV_N-1:0] dq_q1 [DIV_N+1];
  logic [DIV_N-1:0] dq_q2 [DIV_N+1];
  mag_t             dq_n1 [DIV_N+1];
  mag_t             dq_n2 [DIV_N+1];
  dv_carry_t        dq_c  [DIV_N+1];

  always_ff @(posedge clk) begin
    dq_v[0]  <= rst ? 1'b0 : sq_v[64];
    dq_r1[0] <= '0;
    dq_r2[0] <= '0;
    dq_q1[0] <= '0;
    dq_q2[0] <= '0;
    dq_n1[0] <= mag_of(n1);
    dq_n2[0] <= mag_of(n2);
    dq_c[0]  <= '{kill: sq_c[64].kill,
                   neg1: n1[62] ^ sq_c[64].a[62],
                   neg2: n2[62] ^ sq_c[64].a[62],
                   den: mag_of(sq_c[64].a),
                   dv: sq_c[64].dv, xv: sq_c[64].xv};
  end

  for (genvar g = 0; g < DIV_N; g++) begin : g_div
    localparam int B = DIV_N - 1 - g;
    logic        bit1, bit2, ge1, ge2;
    logic [62:0] rs1, rs2;

    if (B >= FRAC_BITS) begin : g_num
      assign bit1 = dq_n1[g][B-FRAC_BITS];
      assign bit2 = dq_n2[g][B-FRAC_BITS];
    end else begin : g_zero
      assign bit1 = 1'b0;
      assign bit2 = 1'b0;
    end

    always_comb begin
      rs1 = {dq_r1[g], bit1};
      rs2 = {dq_r2[g], bit2};
      ge1 = (rs1 >= {1'b0, dq_c[g].den});
      ge2 = (rs2 >= {1'b0, dq_c[g].den});
    end

    always_ff @(posedge clk) begin
      dq_v[g+1]  <= rst ? 1'b0 : dq_v[g];
      dq_r1[g+1] <= ge1 ? 62'(rs1 - {1'b0, dq_c[g].den}) : rs1[61:0];
      dq_r2[g+1] <= ge2 ? 62'(rs2 - {1'b0, dq_c[g].den}) : rs2[61:0];
      dq_q1[g+1] <= {dq_q1[g][DIV_N-2:0], ge1};
      dq_q2[g+1] <= {dq_q2[g][DIV_N-2:0], ge2};
      dq_n1[g+1] <= dq_n1[g];
      dq_n2[g+1] <= dq_n2[g];
      dq_c[g+1]  <= dq_c[g];
    end
  end

  // Stage T: signed, saturated roots t1 and t2
  logic  vt, killt;
  wide_t t1t, t2t, dvt, xvt;

  always_ff @(posedge clk) begin
    vt    <= rst ? 1'b0 : dq_v[DIV_N];
    t1t   <= from_mag((dq_q1[DIV_N] > DIV_N'(MAG_MAX)) ? MAG_MAX : dq_q1[DIV_N][61:0],
                      dq_c[DIV_N].neg1);
    t2t   <= from_mag((dq_q2[DIV_N] > DIV_N'(MAG_MAX)) ? MAG_MAX : dq_q2[DIV_N][61:0],
                      dq_c[DIV_N].neg2);
    killt <= dq_c[DIV_N].kill;
    dvt   <= dq_c[DIV_N].dv;
    xvt   <= dq_c[DIV_N].xv;
  end

  // Stages M1..M4: axial positions, range test and root selection
  logic  vm1, killm1, negm1a, negm1b;
  part_t pp_m1a, pp_m1b;
  wide_t t1m1, t2m1, xvm1;

  always_ff @(posedge clk) begin
    vm1    <= rst ? 1'b0 : vt;
    pp_m1a <= mul_parts(mag_of(dvt), mag_of(t1t));
    pp_m1b <= mul_parts(mag_of(dvt), mag_of(t2t));
    negm1a <= dvt[62] ^ t1t[62];
    negm1b <= dvt[62] ^ t2t[62];
    killm1 <= killt;
    t1m1   <= t1t;
    t2m1   <= t2t;
    xvm1   <= xvt;
  end

  logic  vm2, killm2;
  wide_t pm2a, pm2b, t1m2, t2m2, xvm2;

  always_ff @(posedge clk) begin
    vm2    <= rst ? 1'b0 : vm1;
    pm2a   <= scale_sat(parts_sum(pp_m1a), negm1a, FRAC_BITS);
    pm2b   <= scale_sat(parts_sum(pp_m1b), negm1b, FRAC_BITS);
    killm2 <= killm1;
    t1m2   <= t1m1;
    t2m2   <= t2m1;
    xvm2   <= xvm1;
  end

  logic  vm3, killm3;
  wide_t m1m3, m2m3, t1m3, t2m3;

  always_ff @(posedge clk) begin
    vm3    <= rst ? 1'b0 : vm2;
    m1m3   <= sadd(pm2a, xvm2);
    m2m3   <= sadd(pm2b, xvm2);
    killm3 <= killm2;
    t1m3   <= t1m2;
    t2m3   <= t2m2;
  end

  wide_t span_w, best_sel, bm_sel;
  logic  oor, ok1, ok2, use2;

  always_comb begin
    span_w   = wide_t'({32'b0, span_length});
    oor      = m1m3[62] || (m1m3 > span_w) || m2m3[62] || (m2m3 > span_w);
    ok1      = !t1m3[62];
    ok2      = !t2m3[62];
    // The second root wins when t1 is negative or t2 is strictly nearer, so equal roots keep t1.
    use2     = ok2 && (!ok1 || (t2m3 < t1m3));
    best_sel = use2 ? t2m3 : t1m3;
    bm_sel   = use2 ? m2m3 : m1m3;
  end

  logic  vm4, hitm4;
  wide_t bestm4, bmm4;

  always_ff @(posedge clk) begin
    vm4    <= rst ? 1'b0 : vm3;
    hitm4  <= !killm3 && !oor && (ok1 || ok2);
    bestm4 <= best_sel;
    bmm4   <= bm_sel;
  end

  // Stages A1, A2: axis point B + v*m
  logic  va1, hita1;
  logic  nega1 [3];
  part_t pp_a1 [3];
  wide_t besta1;

  always_ff @(posedge clk) begin
    va1    <= rst ? 1'b0 : vm4;
    hita1  <= hitm4;
    besta1 <= bestm4;
    for (int k = 0; k < 3; k++) begin
      // The zero bit keeps the magnitude of the most negative axis value positive.
      pp_a1[k] <= mul_parts(mag_t'({1'b0, axis_v[k][31] ? 32'(-axis_v[k]) : axis_v[k]}),
                            mag_of(bmm4));
      nega1[k] <= axis_v[k][31] ^ bmm4[62];
    end
  end

  logic  va2, hita2;
  wide_t pa2 [3];
  wide_t besta2;

  always_ff @(posedge clk) begin
    va2    <= rst ? 1'b0 : va1;
    hita2  <= hita1;
    besta2 <= besta1;
    for (int k = 0; k < 3; k++) begin
      pa2[k] <= scale_sat(parts_sum(pp_a1[k]), nega1[k], FRAC_BITS);
    end
  end

  // Result formatting; a miss reports all zeros.
  logic [127:0] wr_data;
  logic [31:0]  ap [3];
  logic [30:0]  hit_dist;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ap[k] = hita2 ? sat32({{32{base_v[k][31]}}, base_v[k]} + {pa2[k][62], pa2[k]}) : '0;
    end
    if (!hita2) begin
      hit_dist = '0;
    end else if (besta2[62:31] != '0) begin
      hit_dist = '1;
    end else begin
      hit_dist = besta2[30:0];
    end
    wr_data = {hita2, ap[2], ap[1], ap[0], hit_dist};
  end

  // Result buffer
  logic [127:0]       fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic               fifo_wr, fifo_rd;
  logic [127:0]       out_q;

  assign fifo_wr = va2;
  assign fifo_rd = (fcnt != '0) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_mem[wptr] <= wr_data;
    end
    if (fifo_rd) begin
      out_q <= fifo_mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr          <= '0;
      rptr          <= '0;
      fcnt          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      wptr <= wptr + FIFO_AW'(fifo_wr);
      rptr <= rptr + FIFO_AW'(fifo_rd);
      fcnt <= fcnt + cnt_t'(fifo_wr) - cnt_t'(fifo_rd);
      if (fifo_rd) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {1'b0, out_q[126:0]};
  assign m_axis_tuser = out_q[127];

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= cnt_t'(FIFO_DEPTH))
    else $error("more requests in flight than the result buffer holds");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_wr |-> (fcnt != cnt_t'(FIFO_DEPTH)) || fifo_rd)
    else $error("result buffer written while full");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss reported with nonzero payload");

  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    (acc_in && !out_acc) |=> (occ == $past(occ) + 1'b1))
    else $error("in-flight count lost a request");

endmodule
